// ===== design/ralu_pkg.sv =====
// Package for the rational ALU: opcodes, widths and shared front/back types.
// Used by the top level, ralu_front, ralu_queue and ralu_back.
package ralu_pkg;
    localparam int OperandWidth = 32;
    localparam int ProdWidth    = 64;
    localparam int QueueDepth   = 2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;
    localparam logic [2:0] OP_CMP = 3'd5;

    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    // Job handed from front to back: numerator sign/magnitude, denominator.
    typedef struct packed {
        logic        reduce;   // run GCD reduction
        logic        nneg;
        logic [63:0] nmag;     // up to 2^63
        logic        dneg;
        logic [63:0] dmag;
        logic [1:0]  cmp;
    } t_job;
endpackage

// ===== design/rational_alu_with_reduction.sv =====
// Top level of the rational ALU with GCD reduction.
// Instantiates ralu_front, ralu_queue and ralu_back; uses ralu_pkg.
//
// Input channel: drive i_op and the four operands with push; the item is taken
// at an edge where push is high and full is low. Results: while empty is low
// the oldest result sits on o_res_num, o_res_den, o_cmp_result and o_den_zero;
// raise pop to take it.
// The front end holds one item while it forms three products on one 32x32
// multiplier and then classifies it. The back end runs a binary GCD, one
// shift or subtract per cycle, then two restoring divisions by the GCD on
// a shared GCD/divide datapath. Compare, zero-denominator and unused
// opcodes bypass it. A two-entry job queue lets the front end take new items
// while the back end works.
// Reset clears all control state; no results are pending afterwards. A stalled
// receiver holds the output register, the back end then waits, the queue fills
// and full stays high.
module rational_alu_with_reduction #(
    parameter int OPERAND_WIDTH = ralu_pkg::OperandWidth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_res_num,
    output logic [62:0] o_res_den,
    output logic [1:0]  o_cmp_result,
    output logic        o_den_zero
);
    ralu_pkg::t_job f_job, q_job;
    logic f_valid, q_ready, q_valid, b_take;

    ralu_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_op, .i_a_num, .i_a_den,
        .i_b_num, .i_b_den, .o_job_valid(f_valid), .i_job_ready(q_ready), .o_job(f_job)
    );
    ralu_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .o_ready(q_ready), .i_data(f_job),
        .o_valid(q_valid), .i_pop(b_take), .o_data(q_job)
    );
    ralu_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_take(b_take), .i_job(q_job),
        .o_empty(empty), .i_pop(pop), .o_res_num, .o_res_den, .o_cmp_result, .o_den_zero
    );
endmodule

// ===== design/ralu_front.sv =====
// Front end: captures an item, forms cross products one after another on one multiplier and
// classifies it into a reduction job. Depends on ralu_pkg.
module ralu_front #(
    parameter int OPERAND_WIDTH = ralu_pkg::OperandWidth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [2:0]          i_op,
    input  logic [31:0]         i_a_num,
    input  logic [31:0]         i_a_den,
    input  logic [31:0]         i_b_num,
    input  logic [31:0]         i_b_den,
    output logic                o_job_valid,
    input  logic                i_job_ready,
    output ralu_pkg::t_job      o_job
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_MUL3 = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_op;
    logic signed [OPERAND_WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [63:0] r_p, r_q, r_d;
    ralu_pkg::t_job n_job;

    logic signed [63:0] an, ad;
    assign an = 64'(r_an);
    assign ad = 64'(r_ad);

    // Multiplier operand selection for the multiply states S_MUL1 to S_MUL3.
    logic signed [OPERAND_WIDTH-1:0] m_x, m_y;
    logic signed [63:0] m_prod;
    always_comb begin
        m_x = r_an;
        m_y = r_bd;
        if (r_state == S_MUL1) begin
            unique case (r_op)
                ralu_pkg::OP_MUL: begin m_x = r_an; m_y = r_bn; end
                default:          begin m_x = r_an; m_y = r_bd; end
            endcase
        end else if (r_state == S_MUL2) begin
            unique case (r_op)
                ralu_pkg::OP_DIV: begin m_x = r_ad; m_y = r_bn; end
                ralu_pkg::OP_MUL: begin m_x = r_ad; m_y = r_bd; end
                default:          begin m_x = r_bn; m_y = r_ad; end
            endcase
        end else begin
            m_x = r_ad;
            m_y = r_bd;
        end
    end
    assign m_prod = 64'(m_x) * 64'(m_y);

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        mag64 = x[63] ? (64'd0 - 64'(x)) : 64'(x);
    endfunction

    logic [63:0] pm, qm, dprod;
    logic        pn, qn;
    always_comb begin
        n_job = '0;
        pm = mag64(r_p);
        qm = mag64(r_q);
        pn = r_p[63];
        qn = r_q[63] ^ (r_op == ralu_pkg::OP_SUB);
        if (r_q == 64'sd0) qn = 1'b0;
        dprod = 64'(r_q);
        n_job.reduce = 1'b1;
        unique case (r_op)
            ralu_pkg::OP_ADD, ralu_pkg::OP_SUB: begin
                if (pn == qn) begin
                    n_job.nneg = pn; n_job.nmag = pm + qm;
                end else if (pm >= qm) begin
                    n_job.nneg = pn; n_job.nmag = pm - qm;
                end else begin
                    n_job.nneg = qn; n_job.nmag = qm - pm;
                end
                dprod = 64'(r_d);
            end
            ralu_pkg::OP_MUL, ralu_pkg::OP_DIV: begin
                n_job.nneg = pn; n_job.nmag = pm;
            end
            ralu_pkg::OP_NEG: begin
                n_job.nneg = ~an[63]; n_job.nmag = mag64(an);
                dprod = 64'(ad);
            end
            ralu_pkg::OP_CMP: begin
                n_job.reduce = 1'b0;
                n_job.cmp = (r_p < r_q) ? ralu_pkg::CMP_LT :
                            (r_p == r_q) ? ralu_pkg::CMP_EQ : ralu_pkg::CMP_GT;
            end
            default: n_job.reduce = 1'b0;
        endcase
        if (n_job.nmag == 64'd0) n_job.nneg = 1'b0;
        n_job.dneg = dprod[63];
        n_job.dmag = mag64(dprod);
        if (!n_job.reduce) begin
            n_job.dneg = 1'b0;
            n_job.dmag = 64'd0;
        end
    end

    // The add/sub denominator a_den*b_den is formed in state S_MUL3.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_push) n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_OUT;
            S_OUT:  if (i_job_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == S_IDLE && i_push) begin
            r_op <= i_op;
            r_an <= i_a_num[OPERAND_WIDTH-1:0];
            r_ad <= i_a_den[OPERAND_WIDTH-1:0];
            r_bn <= i_b_num[OPERAND_WIDTH-1:0];
            r_bd <= i_b_den[OPERAND_WIDTH-1:0];
        end
        if (r_state == S_MUL1) r_p <= m_prod;
        if (r_state == S_MUL2) begin
            r_q <= m_prod;
        end
        if (r_state == S_MUL3) r_d <= m_prod;
    end

    // Job is built combinationally from registered products in S_OUT.
    assign o_full      = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_OUT);
    assign o_job       = n_job;
endmodule

// ===== design/ralu_queue.sv =====
// Short queue between front end and back end. Depends on ralu_pkg.
module ralu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  ralu_pkg::t_job i_data,
    output logic           o_valid,
    input  logic           i_pop,
    output ralu_pkg::t_job o_data
);
    ralu_pkg::t_job r_mem [ralu_pkg::QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    logic do_push, do_pop;
    assign o_ready = (r_cnt != 2'(ralu_pkg::QueueDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== design/ralu_back.sv =====
// Back end: binary GCD of magnitudes, then two restoring divisions by the GCD,
// saturation and sign placement into an output register. Depends on ralu_pkg.
module ralu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_take,
    input  ralu_pkg::t_job i_job,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [63:0]    o_res_num,
    output logic [62:0]    o_res_den,
    output logic [1:0]     o_cmp_result,
    output logic           o_den_zero
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIVN = 3'd2;
    localparam logic [2:0] S_DIVD = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  r_state;
    ralu_pkg::t_job r_job;
    logic [63:0] r_x, r_y, r_g;
    logic [6:0]  r_sh;
    logic [5:0]  r_bit;
    logic [64:0] r_rem;
    logic [63:0] r_quo, r_qn;
    logic        r_full;
    logic [63:0] r_onum;
    logic [62:0] r_oden;
    logic [1:0]  r_ocmp;
    logic        r_oz;

    assign o_take = (r_state == S_IDLE) && i_valid;

    // Restoring divide step: dividend bit from r_quo MSB.
    logic [64:0] trial;
    assign trial = {r_rem[63:0], r_quo[63]} - {1'b0, r_g};

    logic [63:0] nfin, sat;
    logic rneg;
    always_comb begin
        sat = (r_qn > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : r_qn;
        rneg = (r_qn != 64'd0) && (r_job.nneg != r_job.dneg);
        nfin = rneg ? (64'd0 - sat) : sat;
    end

    logic load_out;
    assign load_out = (r_state == S_DONE) && (!r_full || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full  <= 1'b0;
        end else begin
            if (load_out) r_full <= 1'b1;
            else if (r_full && i_pop) r_full <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_x <= i_job.nmag;
                    r_y <= i_job.dmag;
                    r_sh <= 7'd0;
                    if (i_job.reduce && i_job.dmag != 64'd0) begin
                        r_state <= S_GCD;
                    end else begin
                        r_qn <= i_job.nmag;
                        r_state <= S_DONE;
                    end
                end
                S_GCD: begin
                    // Binary GCD: one shift or subtract per cycle.
                    if (r_x == 64'd0) begin
                        r_g <= r_y << r_sh;
                        r_rem <= '0; r_quo <= r_job.nmag; r_bit <= 6'd63;
                        r_state <= S_DIVN;
                    end else if (r_y == 64'd0) begin
                        r_g <= r_x << r_sh;
                        r_rem <= '0; r_quo <= r_job.nmag; r_bit <= 6'd63;
                        r_state <= S_DIVN;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1; r_y <= r_y >> 1; r_sh <= r_sh + 7'd1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x >= r_y) begin
                        r_x <= (r_x - r_y) >> 1;
                    end else begin
                        r_y <= (r_y - r_x) >> 1;
                    end
                end
                S_DIVN, S_DIVD: begin
                    if (!trial[64]) begin
                        r_rem <= trial;
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[63:0], r_quo[63]};
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd0) begin
                        if (r_state == S_DIVN) begin
                            r_qn <= {r_quo[62:0], !trial[64]};
                            r_rem <= '0; r_quo <= r_job.dmag; r_bit <= 6'd63;
                            r_state <= S_DIVD;
                        end else begin
                            r_y <= {r_quo[62:0], !trial[64]};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: if (load_out) begin
                    r_onum <= r_job.reduce ? nfin : 64'd0;
                    r_oden <= (r_job.reduce && r_job.dmag != 64'd0) ? r_y[62:0] : 63'd0;
                    r_ocmp <= r_job.cmp;
                    r_oz   <= r_job.reduce && (r_job.dmag == 64'd0);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty      = !r_full;
    assign o_res_num    = r_onum;
    assign o_res_den    = r_oden;
    assign o_cmp_result = r_ocmp;
    assign o_den_zero   = r_oz;
endmodule

// ===== design/ralu_checker.sv =====
// Port-level checker for rational_alu_with_reduction, bound to the top level.
// Uses only the top level's ports.
module ralu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [63:0] o_res_num,
    input logic [62:0] o_res_den,
    input logic [1:0]  o_cmp_result,
    input logic        o_den_zero
);
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res_num) && $stable(o_res_den)))
        else $error("result changed while stalled");
    a_cmp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_cmp_result != 2'd3)) else $error("bad compare code");
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_den_zero) |-> (o_res_den == 63'd0 && o_cmp_result == 2'd0))
        else $error("den_zero with nonzero denominator");
    a_cmp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_cmp_result != 2'd0) |-> (o_res_num == 64'd0 && !o_den_zero))
        else $error("compare result with data");
endmodule

bind rational_alu_with_reduction ralu_checker u_ralu_checker (
    .i_clk, .i_rst_n, .empty, .pop, .o_res_num, .o_res_den, .o_cmp_result,
    .o_den_zero
);
